// File: hw/rtl/qtg_pkg.sv
// ----------------------------------------------------------------------------
// qtg_pkg
// Shared widths for the quintic trajectory generator and its arithmetic units.
// ----------------------------------------------------------------------------
package qtg_pkg;

    // field widths
    localparam int POS_W   = 32;   // signed Q16.16 position
    localparam int DUR_W   = 24;   // duration in microseconds
    localparam int TICK_W  = 16;   // tick time in microseconds
    localparam int TIME_W  = 32;   // elapsed time in microseconds

    // digit width of the shared multiplier
    localparam int DIGIT_W = 16;

endpackage

// File: hw/rtl/qtg_div.sv
// ----------------------------------------------------------------------------
// qtg_div
// Radix-2 restoring divider: quotient of (num * 2^QW) / den for num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qtg_div
    import qtg_pkg::*;
#(
    parameter int QW = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DUR_W-1:0]  i_num,
    input  logic [DUR_W-1:0]  i_den,
    output logic              o_done,
    output logic [QW-1:0]     o_quot
);

    localparam int CW = $clog2(QW + 1);

    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] r_den;
    logic [QW-1:0]    r_quot;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DUR_W:0]   rem2;
    logic [DUR_W:0]   den_x;
    logic [DUR_W:0]   diff;
    logic             ge;

    // one trial subtraction per cycle
    assign rem2  = {r_rem, 1'b0};
    assign den_x = {1'b0, r_den};
    assign ge    = (rem2 >= den_x);
    assign diff  = rem2 - den_x;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DUR_W-1:0] : rem2[DUR_W-1:0];
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: hw/rtl/qtg_mac.sv
// ----------------------------------------------------------------------------
// qtg_mac
// Shared digit-serial multiplier: a times b, one 16-bit digit of b per cycle,
// most significant digit first.
// ----------------------------------------------------------------------------
module qtg_mac
    import qtg_pkg::*;
#(
    parameter int AW = 25,
    parameter int ND = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [AW-1:0]              i_a,
    input  logic [ND*DIGIT_W-1:0]      i_b,
    output logic                       o_done,
    output logic [AW+ND*DIGIT_W-1:0]   o_prod
);

    localparam int BW = ND * DIGIT_W;
    localparam int PW = AW + BW;
    localparam int CW = $clog2(ND + 1);

    logic [AW-1:0]         r_a;
    logic [BW-1:0]         r_b;
    logic [PW-1:0]         r_acc;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [AW+DIGIT_W-1:0] part;
    logic [PW-1:0]         n_acc;

    // partial product of the top digit, accumulated after a digit shift
    assign part  = r_a * r_b[BW-1 -: DIGIT_W];
    assign n_acc = {r_acc[PW-DIGIT_W-1:0], DIGIT_W'(0)} + PW'(part);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ND);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= r_b << DIGIT_W;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: hw/rtl/quintic_trajectory_generator.sv
// ----------------------------------------------------------------------------
// quintic_trajectory_generator
// Point-to-point minimum-jerk setpoint generator with a divider and a shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One request is handled at a time. A restart request clears the elapsed
// time and gives no result. A step request past the move (or with a zero
// duration) goes from S_CHECK straight to S_WRITE; a request at the end of
// the move skips the divider and makes one multiplier pass for the offset. A
// request on the curve runs the bit-serial divider that forms s, then four
// passes through the 16-bit-digit multiplier (s^2, s^3, the blend and the
// offset), which takes its b operand in ND digits, ND being
// ceil(max(FRACTION_BITS+4,32)/16). A finished result sits in an output
// register, so the next request can be taken while it waits; a step result
// that finds that register still full holds the block until it drains.
// ----------------------------------------------------------------------------
module quintic_trajectory_generator
    import qtg_pkg::*;
#(
    parameter int FRACTION_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_op,
    input  logic signed [POS_W-1:0]  i_start_pos,
    input  logic signed [POS_W-1:0]  i_target_pos,
    input  logic [DUR_W-1:0]         i_duration,
    input  logic [TICK_W-1:0]        i_tick_time,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [POS_W-1:0]  o_position
);

    localparam int F    = FRACTION_BITS;
    localparam int QW   = F + 4;
    localparam int BMAX = (QW > POS_W) ? QW : POS_W;
    localparam int ND   = (BMAX + DIGIT_W - 1) / DIGIT_W;
    localparam int BW   = ND * DIGIT_W;
    localparam int AW   = F + 1;
    localparam int PW   = AW + BW;

    localparam logic [F:0]    P_ONE = {1'b1, {F{1'b0}}};
    localparam logic [QW-1:0] Q_TEN = {4'd10, {F{1'b0}}};

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_CHECK = 12'b0000_0000_0010,
        S_DIV   = 12'b0000_0000_0100,
        S_SQ    = 12'b0000_0000_1000,
        S_Q1    = 12'b0000_0001_0000,
        S_Q2    = 12'b0000_0010_0000,
        S_CUBE  = 12'b0000_0100_0000,
        S_BLEND = 12'b0000_1000_0000,
        S_OFFS  = 12'b0001_0000_0000,
        S_OFF   = 12'b0010_0000_0000,
        S_SUM   = 12'b0100_0000_0000,
        S_WRITE = 12'b1000_0000_0000
    } t_state;

    // registers
    t_state                  r_state,   n_state;
    logic [TIME_W-1:0]       r_elapsed, n_elapsed;
    logic signed [POS_W-1:0] r_origin,  n_origin;
    logic                    r_neg,     n_neg;
    logic [POS_W-1:0]        r_mag,     n_mag;
    logic [DUR_W-1:0]        r_ldur,    n_ldur;
    logic signed [POS_W-1:0] r_target,  n_target;
    logic [DUR_W-1:0]        r_dur,     n_dur;
    logic [F-1:0]            r_s,       n_s;
    logic [F-1:0]            r_s2,      n_s2;
    logic [QW-1:0]           r_q,       n_q;
    logic [F:0]              r_p,       n_p;
    logic [POS_W-1:0]        r_off,     n_off;
    logic signed [POS_W-1:0] r_res,     n_res;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_out_pos;

    // arithmetic unit hookup
    logic                    div_start;
    logic                    div_done;
    logic [F-1:0]            div_quot;
    logic                    mac_start;
    logic [AW-1:0]           mac_a;
    logic [BW-1:0]           mac_b;
    logic                    mac_done;
    logic [PW-1:0]           mac_prod;

    // helpers
    logic                    in_fire;
    logic                    out_load;
    logic [TIME_W:0]         time_sum;
    logic [POS_W:0]          up_span;
    logic [POS_W:0]          dn_span;
    logic [QW-1:0]           blend_raw;
    logic signed [POS_W+1:0] pos_sum;

    qtg_div #(
        .QW (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_elapsed[DUR_W-1:0]),
        .i_den   (r_ldur),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    qtg_mac #(
        .AW (AW),
        .ND (ND)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_done  (mac_done),
        .o_prod  (mac_prod)
    );

    // handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_WRITE) && (!r_out_valid || i_out_ready);

    // saturating time advance and span magnitude
    assign time_sum  = {1'b0, r_elapsed} + (TIME_W+1)'(i_tick_time);
    assign up_span   = {i_target_pos[POS_W-1], i_target_pos}
                     - {i_start_pos[POS_W-1], i_start_pos};
    assign dn_span   = {i_start_pos[POS_W-1], i_start_pos}
                     - {i_target_pos[POS_W-1], i_target_pos};
    assign blend_raw = mac_prod[F +: QW];

    // origin plus signed offset, wide enough to saturate afterward
    assign pos_sum = r_neg
        ? ({{2{r_origin[POS_W-1]}}, r_origin} - $signed({2'b00, r_off}))
        : ({{2{r_origin[POS_W-1]}}, r_origin} + $signed({2'b00, r_off}));

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_elapsed = r_elapsed;
        n_origin  = r_origin;
        n_neg     = r_neg;
        n_mag     = r_mag;
        n_ldur    = r_ldur;
        n_target  = r_target;
        n_dur     = r_dur;
        n_s       = r_s;
        n_s2      = r_s2;
        n_q       = r_q;
        n_p       = r_p;
        n_off     = r_off;
        n_res     = r_res;
        div_start = 1'b0;
        mac_start = 1'b0;
        mac_a     = AW'(r_s);
        mac_b     = BW'(r_s);
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_op) begin
                        n_elapsed = '0;
                    end else begin
                        if (r_elapsed == '0) begin
                            n_origin = i_start_pos;
                            n_neg    = up_span[POS_W];
                            n_mag    = up_span[POS_W] ? dn_span[POS_W-1:0]
                                                      : up_span[POS_W-1:0];
                            n_ldur   = i_duration;
                        end
                        n_elapsed = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
                        n_target  = i_target_pos;
                        n_dur     = i_duration;
                        n_state   = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if ((r_elapsed > TIME_W'(r_dur)) || (r_ldur == '0)) begin
                    n_res   = r_target;
                    n_state = S_WRITE;
                end else if (r_elapsed >= TIME_W'(r_ldur)) begin
                    n_p     = P_ONE;
                    n_state = S_OFFS;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_s       = div_quot;
                    mac_start = 1'b1;
                    mac_a     = AW'(div_quot);
                    mac_b     = BW'(div_quot);
                    n_state   = S_SQ;
                end
            end
            S_SQ: begin
                if (mac_done) begin
                    n_s2    = mac_prod[F +: F];
                    n_state = S_Q1;
                end
            end
            S_Q1: begin
                // 10 + 6*s^2
                n_q     = Q_TEN + {2'b00, r_s2, 2'b00} + {3'b000, r_s2, 1'b0};
                n_state = S_Q2;
            end
            S_Q2: begin
                // minus 15*s, while the cube runs
                n_q       = r_q - ({r_s, 4'b0000} - {4'b0000, r_s});
                mac_start = 1'b1;
                mac_a     = AW'(r_s2);
                mac_b     = BW'(r_s);
                n_state   = S_CUBE;
            end
            S_CUBE: begin
                if (mac_done) begin
                    mac_start = 1'b1;
                    mac_a     = AW'(mac_prod[F +: F]);
                    mac_b     = BW'(r_q);
                    n_state   = S_BLEND;
                end
            end
            S_BLEND: begin
                if (mac_done) begin
                    n_p     = (blend_raw > QW'(P_ONE)) ? P_ONE : blend_raw[F:0];
                    n_state = S_OFFS;
                end
            end
            S_OFFS: begin
                mac_start = 1'b1;
                mac_a     = r_p;
                mac_b     = BW'(r_mag);
                n_state   = S_OFF;
            end
            S_OFF: begin
                if (mac_done) begin
                    n_off   = mac_prod[F +: POS_W];
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // saturate to the 32-bit range
                if (pos_sum[POS_W+1:POS_W-1] == 3'b000 ||
                    pos_sum[POS_W+1:POS_W-1] == 3'b111) begin
                    n_res = pos_sum[POS_W-1:0];
                end else if (pos_sum[POS_W+1]) begin
                    n_res = {1'b1, {(POS_W-1){1'b0}}};
                end else begin
                    n_res = {1'b0, {(POS_W-1){1'b1}}};
                end
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and trajectory state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_origin    <= '0;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_ldur      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
            r_origin  <= n_origin;
            r_neg     <= n_neg;
            r_mag     <= n_mag;
            r_ldur    <= n_ldur;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_dur    <= n_dur;
        r_s      <= n_s;
        r_s2     <= n_s2;
        r_q      <= n_q;
        r_p      <= n_p;
        r_off    <= n_off;
        r_res    <= n_res;
        if (out_load) begin
            r_out_pos <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;

endmodule
